// File: design/mfm_pkg.sv
package mfm_pkg;

  localparam int unsigned ADDR_W = 10;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned PRE_W = 6;
  localparam int unsigned POS_W = 7;
  localparam int unsigned FRAME_W = 32;

  localparam logic [PRE_W-1:0] PREAMBLE_RESET = 6'd32;

  localparam logic [1:0] START_CODE = 2'b01;
  localparam logic [1:0] OP_READ = 2'b10;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] TA_WRITE = 2'b10;

  localparam logic [POS_W-1:0] READ_ADDR_END = 7'd14;
  localparam logic [POS_W-1:0] READ_SAMPLE_FIRST = 7'd15;
  localparam logic [POS_W-1:0] READ_LAST_BIT = 7'd30;
  localparam logic [POS_W-1:0] WRITE_LAST_BIT = 7'd31;

  typedef struct packed {
    logic              clock_pulse;
    logic              data_out;
    logic              data_drive;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] read_data;
  } result_t;

endpackage

// File: design/mfm_core.sv
module mfm_core import mfm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [PRE_W-1:0]  cfg_wdata,
  input  logic              accept,
  input  logic              start_request,
  input  logic              operation,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] write_data,
  input  logic              data_in,
  output result_t           res
);

  logic [PRE_W-1:0]   preamble_length;
  logic [POS_W-1:0]   bit_position;
  logic [FRAME_W-1:0] out_shift;
  logic [DATA_W-1:0]  in_shift;
  logic               frame_active;
  logic               frame_is_read;

  logic [POS_W-1:0]   bit_position_next;
  logic [FRAME_W-1:0] out_shift_next;
  logic [DATA_W-1:0]  in_shift_next;
  logic               frame_active_next;
  logic               frame_is_read_next;

  logic               start;
  logic [POS_W-1:0]   k;
  logic [4:0]         tap;

  always_comb begin
    start = !frame_active && start_request;
    frame_active_next = frame_active || start;
    frame_is_read_next = start ? operation : frame_is_read;
    bit_position_next = start ? '0 : bit_position;
    in_shift_next = (start && operation) ? '0 : in_shift;
    if (!start) begin
      out_shift_next = out_shift;
    end else if (operation) begin
      out_shift_next = {START_CODE, OP_READ, address, 18'd0};
    end else begin
      out_shift_next = {START_CODE, OP_WRITE, address, TA_WRITE, write_data};
    end

    k = bit_position_next - {1'b0, preamble_length};
    tap = 5'd31 - k[4:0];

    res.clock_pulse = 1'b0;
    res.data_out = 1'b1;
    res.data_drive = 1'b1;
    res.busy_res = 1'b0;
    res.done_res = 1'b0;

    if (frame_active_next) begin
      res.clock_pulse = 1'b1;
      res.busy_res = 1'b1;
      if (bit_position_next >= {1'b0, preamble_length}) begin
        if (frame_is_read_next) begin
          if (k < READ_ADDR_END) begin
            res.data_out = out_shift_next[tap];
          end else begin
            res.data_drive = 1'b0;
            res.data_out = 1'b0;
            if (k >= READ_SAMPLE_FIRST && k <= READ_LAST_BIT) begin
              in_shift_next = {in_shift_next[DATA_W-2:0], data_in};
            end
          end
          res.done_res = (k >= READ_LAST_BIT);
        end else begin
          if (k <= WRITE_LAST_BIT) begin
            res.data_out = out_shift_next[tap];
          end
          res.done_res = (k >= WRITE_LAST_BIT);
        end
      end
      if (res.done_res) begin
        frame_active_next = 1'b0;
        bit_position_next = '0;
      end else begin
        bit_position_next = bit_position_next + 7'd1;
      end
    end
    res.read_data = in_shift_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_length <= PREAMBLE_RESET;
      bit_position <= '0;
      out_shift <= '0;
      in_shift <= '0;
      frame_active <= 1'b0;
      frame_is_read <= 1'b0;
    end else begin
      if (cfg_we) begin
        preamble_length <= cfg_wdata;
      end
      if (accept) begin
        bit_position <= bit_position_next;
        out_shift <= out_shift_next;
        in_shift <= in_shift_next;
        frame_active <= frame_active_next;
        frame_is_read <= frame_is_read_next;
      end
    end
  end

endmodule

// File: design/mfm_out_stage.sv
module mfm_out_stage import mfm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  input  logic    m_tready,
  output logic    ready,
  output logic    m_tvalid,
  output result_t res_out
);

  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// File: design/mdio_frame_master.sv
// Each accepted beat's result is captured in the output register and driven on m_tdata from it.
// Throughput: one beat per cycle while m_tready is high; each beat is one management clock bit period.
// The single result register sets the rate; s_tready stays high while m_tready is high.
// Reset (rst, synchronous, active high): idle, no frame, preamble length 32,
// read data cleared, output register empty.
module mdio_frame_master import mfm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [PRE_W-1:0]       cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,   // start_request, address, write_data, data_in
  input  logic                   s_tuser,   // operation
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [23:0]            m_tdata,   // clock_pulse, data_out, data_drive, busy_res,
                                            // read_data
  output logic                   m_tlast    // done_res
);

  logic    accept;
  result_t res;
  result_t res_q;

  assign accept = s_tvalid && s_tready;

  mfm_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .accept        (accept),
    .start_request (s_tdata[0]),
    .operation     (s_tuser),
    .address       (s_tdata[10:1]),
    .write_data    (s_tdata[26:11]),
    .data_in       (s_tdata[27]),
    .res           (res)
  );

  mfm_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .res_in   (res),
    .m_tready (m_tready),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .res_out  (res_q)
  );

  assign m_tdata = {4'd0, res_q.read_data, res_q.busy_res, res_q.data_drive,
                    res_q.data_out, res_q.clock_pulse};
  assign m_tlast = res_q.done_res;

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[3] && m_tdata[0])
    else $error("done beat outside a frame");

  a_release_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> !m_tdata[1] && m_tdata[3])
    else $error("released line not low or outside a frame");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[3] |-> !m_tdata[0] && m_tdata[1] && m_tdata[2] && !m_tlast)
    else $error("idle beat not driven high");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready out of step with result register");

endmodule
